/* hdl/pps_pkg.sv */
// Shared types and constants of the preemptive priority scheduler.
package pps_pkg;

    // Kind of an input transaction, carried on s_axis_tuser
    typedef enum logic
    {
        ACT_LOAD = 1'b0,
        ACT_TICK = 1'b1
    } action_t;

    // Fixed field widths of the stream payloads
    localparam int SLOT_FW     = 3;
    localparam int TIME_FW     = 16;
    localparam int PRIO_W      = 8;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 56;

endpackage

/* hdl/pps_task_store.sv */
// Task slot table: one write port, one registered read port, per-slot loaded bits.
module pps_task_store #(
    parameter int NUM_SLOTS  = 8,
    parameter int TIME_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [$clog2(NUM_SLOTS)-1:0]    wr_addr,
    input  logic [TIME_WIDTH-1:0]           wr_arrival,
    input  logic [TIME_WIDTH-1:0]           wr_burst,
    input  logic [TIME_WIDTH-1:0]           wr_remaining,
    input  logic [pps_pkg::PRIO_W-1:0]      wr_priority,
    input  logic [$clog2(NUM_SLOTS)-1:0]    rd_addr,
    output logic                            rd_loaded,
    output logic [TIME_WIDTH-1:0]           rd_arrival,
    output logic [TIME_WIDTH-1:0]           rd_burst,
    output logic [TIME_WIDTH-1:0]           rd_remaining,
    output logic [pps_pkg::PRIO_W-1:0]      rd_priority
);
    import pps_pkg::*;

    localparam int ENTRY_W  = 3 * TIME_WIDTH + PRIO_W;

    logic [ENTRY_W-1:0]   mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] loaded_reg;
    logic [ENTRY_W-1:0]   rd_data_reg;
    logic                 rd_loaded_reg;

    // Loaded bits: an unloaded slot reads as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg    <= '0;
            rd_loaded_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                loaded_reg[wr_addr] <= 1'b1;
            end
            rd_loaded_reg <= loaded_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_priority, wr_remaining, wr_burst, wr_arrival};
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_loaded    = rd_loaded_reg;
    assign rd_arrival   = rd_data_reg[TIME_WIDTH-1:0];
    assign rd_burst     = rd_data_reg[2*TIME_WIDTH-1:TIME_WIDTH];
    assign rd_remaining = rd_data_reg[3*TIME_WIDTH-1:2*TIME_WIDTH];
    assign rd_priority  = rd_data_reg[ENTRY_W-1:3*TIME_WIDTH];

endmodule

/* hdl/preemptive_priority_scheduler.sv */
// Top level of the preemptive priority scheduler: sequencer, slot scan and result register.
//
// Usage:
//   Input stream (s_axis_*): one transaction is either a load or a tick, chosen by
//   s_axis_tuser. A load writes one task slot (arrival, burst, priority) and arms it
//   with its full burst; loads to slots at or above NUM_SLOTS are dropped. A tick
//   picks the arrived, unfinished slot with the smallest priority value (ties go to
//   the lowest slot), runs it for one time unit, then advances the time counter,
//   which saturates at its maximum.
//   Output stream (m_axis_*): one result per tick, none per load. The result tells
//   whether a slot ran, which one, and on completion its completion, turnaround and
//   waiting times.
// Timing:
//   A load is written to the slot table as it is accepted. A tick runs from acceptance
//   through the scan to the result register: the scan reads one slot per cycle through
//   the single read port of the slot table and one shared comparator, followed by
//   the slot update and two subtract steps. The block accepts one transaction at a
//   time and is not ready while a tick is in progress.
// Reset clears the time counter, marks every slot empty and empties the result
// register. When the receiver stalls, the result is held; a finished tick waits in
// its last step until the result register frees up, and no transaction is taken meanwhile.
module preemptive_priority_scheduler #(
    parameter int NUM_SLOTS  = 8,
    parameter int TIME_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [2:0] slot, [18:3] arrival, [34:19] burst, [42:35] priority_req, [47:43] zero
    input  logic [pps_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [0] action
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] ran, [3:1] run_slot, [4] finished, [20:5] completion_time,
    // [36:21] turnaround, [52:37] waiting, [55:53] zero
    output logic [pps_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
    import pps_pkg::*;

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SCAN,
        S_UPD,
        S_TAT,
        S_WT,
        S_DONE
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   found_reg, found_next;
    logic [TIME_WIDTH-1:0]  now_reg, now_next;
    logic                   out_valid_reg, out_valid_next;

    // Best candidate of the scan and the result pipeline
    logic [SLOT_W-1:0]      best_idx_reg;
    logic [PRIO_W-1:0]      best_prio_reg;
    logic [TIME_WIDTH-1:0]  best_arrival_reg;
    logic [TIME_WIDTH-1:0]  best_burst_reg;
    logic [TIME_WIDTH-1:0]  best_rem_reg;
    logic                   fin_reg;
    logic [TIME_WIDTH-1:0]  ct_reg;
    logic [TIME_WIDTH-1:0]  tat_reg;
    logic [TIME_WIDTH-1:0]  wt_reg;

    logic                   out_ran_reg;
    logic [SLOT_FW-1:0]     out_slot_reg;
    logic                   out_fin_reg;
    logic [TIME_FW-1:0]     out_ct_reg;
    logic [TIME_FW-1:0]     out_tat_reg;
    logic [TIME_FW-1:0]     out_wt_reg;

    // Input fields
    logic [SLOT_FW-1:0]     in_slot;
    logic [TIME_FW-1:0]     in_arrival;
    logic [TIME_FW-1:0]     in_burst;
    logic [PRIO_W-1:0]      in_priority;
    logic                   in_fire;
    logic                   load_fire;
    logic                   tick_fire;
    logic                   slot_ok;

    // Slot table ports
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_addr;
    logic [TIME_WIDTH-1:0]  wr_arrival;
    logic [TIME_WIDTH-1:0]  wr_burst;
    logic [TIME_WIDTH-1:0]  wr_remaining;
    logic [PRIO_W-1:0]      wr_priority;
    logic [SLOT_W-1:0]      rd_addr;
    logic                   rd_loaded;
    logic [TIME_WIDTH-1:0]  rd_arrival;
    logic [TIME_WIDTH-1:0]  rd_burst;
    logic [TIME_WIDTH-1:0]  rd_remaining;
    logic [PRIO_W-1:0]      rd_priority;

    // Scan and update helpers
    logic                   cmp_en;
    logic [SLOT_W-1:0]      cmp_idx;
    logic                   better;
    logic [TIME_WIDTH-1:0]  rem_dec;
    logic [TIME_WIDTH-1:0]  now_inc;
    logic                   load_out;

    assign in_slot     = s_axis_tdata[2:0];
    assign in_arrival  = s_axis_tdata[18:3];
    assign in_burst    = s_axis_tdata[34:19];
    assign in_priority = s_axis_tdata[42:35];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign load_fire     = in_fire && (action_t'(s_axis_tuser) == ACT_LOAD);
    assign tick_fire     = in_fire && (action_t'(s_axis_tuser) == ACT_TICK);
    assign slot_ok       = (32'(in_slot) < 32'(NUM_SLOTS));

    // Compare the slot read in the previous cycle against the best so far
    assign cmp_en  = (state_reg == S_SCAN) && (cnt_reg != '0);
    assign cmp_idx = SLOT_W'(cnt_reg - CNT_W'(1));
    assign better  = cmp_en && rd_loaded && (rd_arrival <= now_reg)
                     && (rd_remaining != '0)
                     && (!found_reg || (rd_priority < best_prio_reg));

    assign rd_addr = (cnt_reg < CNT_W'(NUM_SLOTS)) ? SLOT_W'(cnt_reg) : '0;

    assign rem_dec = best_rem_reg - TIME_WIDTH'(1);
    assign now_inc = (now_reg == '1) ? now_reg : now_reg + TIME_WIDTH'(1);

    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || m_axis_tready);

    // Write port: loads in idle, the run slot's countdown after a scan
    always_comb
    begin
        if (state_reg == S_UPD)
        begin
            wr_en        = found_reg;
            wr_addr      = best_idx_reg;
            wr_arrival   = best_arrival_reg;
            wr_burst     = best_burst_reg;
            wr_remaining = rem_dec;
            wr_priority  = best_prio_reg;
        end
        else
        begin
            wr_en        = load_fire && slot_ok;
            wr_addr      = SLOT_W'(in_slot);
            wr_arrival   = TIME_WIDTH'(in_arrival);
            wr_burst     = TIME_WIDTH'(in_burst);
            wr_remaining = TIME_WIDTH'(in_burst);
            wr_priority  = in_priority;
        end
    end

    pps_task_store #(
        .NUM_SLOTS  (NUM_SLOTS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_arrival   (wr_arrival),
        .wr_burst     (wr_burst),
        .wr_remaining (wr_remaining),
        .wr_priority  (wr_priority),
        .rd_addr      (rd_addr),
        .rd_loaded    (rd_loaded),
        .rd_arrival   (rd_arrival),
        .rd_burst     (rd_burst),
        .rd_remaining (rd_remaining),
        .rd_priority  (rd_priority)
    );

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        found_next     = found_reg;
        now_next       = now_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (better)
        begin
            found_next = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (tick_fire)
                begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                    found_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                // Issue one read per cycle; the last compare lands as the count ends
                if (cnt_reg == CNT_W'(NUM_SLOTS))
                begin
                    state_next = S_UPD;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_UPD:
            begin
                now_next   = now_inc;
                state_next = S_TAT;
            end
            S_TAT:
            begin
                state_next = S_WT;
            end
            S_WT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            found_reg     <= 1'b0;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            found_reg     <= found_next;
            now_reg       <= now_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath: one compare or subtract per step
    always_ff @(posedge clk)
    begin
        if (better)
        begin
            best_idx_reg     <= cmp_idx;
            best_prio_reg    <= rd_priority;
            best_arrival_reg <= rd_arrival;
            best_burst_reg   <= rd_burst;
            best_rem_reg     <= rd_remaining;
        end
        if (state_reg == S_UPD)
        begin
            fin_reg <= found_reg && (rem_dec == '0);
            ct_reg  <= now_inc;
        end
        if (state_reg == S_TAT)
        begin
            tat_reg <= ct_reg - best_arrival_reg;
        end
        if (state_reg == S_WT)
        begin
            // Floor at zero once the saturated clock stops moving
            wt_reg <= (tat_reg >= best_burst_reg) ? tat_reg - best_burst_reg : '0;
        end
        if (load_out)
        begin
            out_ran_reg  <= found_reg;
            out_slot_reg <= found_reg ? SLOT_FW'(best_idx_reg) : '0;
            out_fin_reg  <= fin_reg;
            out_ct_reg   <= fin_reg ? TIME_FW'(ct_reg) : '0;
            out_tat_reg  <= fin_reg ? TIME_FW'(tat_reg) : '0;
            out_wt_reg   <= fin_reg ? TIME_FW'(wt_reg) : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_wt_reg, out_tat_reg, out_ct_reg,
                            out_fin_reg, out_slot_reg, out_ran_reg};

    // A finished result always reports a slot that ran
    a_fin_implies_ran: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[4] || m_axis_tdata[0]))
        else $error("finished result without a running slot");

    // The time counter never moves backward
    a_now_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (now_reg >= $past(now_reg)))
        else $error("time counter went backward");

    // The slot table is written only by a load or by the post-scan update
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((state_reg == S_IDLE) || (state_reg == S_UPD)))
        else $error("slot table written outside load or update");

    // Waiting time never exceeds turnaround on a finished tick
    a_wait_le_tat: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && fin_reg) |-> (wt_reg <= tat_reg))
        else $error("waiting time exceeds turnaround");

endmodule
